/* rtl/core/wtraj_pkg.sv */
// Shared types and constants for the waypoint trajectory interpolator.
// No dependencies; imported by the core and by the divider.
package wtraj_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_JOINTS = 8;
    localparam int POS_W      = 16;
    localparam int PT_W       = $clog2(MAX_POINTS);
    localparam int JT_W       = $clog2(MAX_JOINTS);
    localparam int EL_W       = 18;
    localparam int TICK_W     = 16;
    localparam int PROD_W     = 32;  // magnitude of (end-start)*elapsed
    localparam int DCNT_W     = $clog2(PROD_W);

    typedef enum logic [2:0] {
        FN_WR_POS  = 3'd0,
        FN_WR_TIM  = 3'd1,
        FN_START   = 3'd2,
        FN_SAMPLE  = 3'd3,
        FN_STOP    = 3'd4,
        FN_TICK    = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] move;
        logic [TICK_W-1:0] dwell;
        logic              mode;
    } timing_t;

    // Divider handshake from the sequencer
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [TICK_W-1:0] divisor;
    } div_req_t;

endpackage

/* rtl/core/waypoint_trajectory_interpolator_core.sv */
// Waypoint trajectory interpolator: waypoint memories, tick sequencer, output register.
// Depends on wtraj_pkg and wtraj_div.
//
// One input word is taken at a time. Writes, start, sample and stop are
// handled in the idle state. A tick that commands the arm gives one output word
// per joint in use; each joint passes through memory reads, multiply, divide
// start and output, with the bit-serial divide in between for linear moves,
// plus any output stall. Waypoint positions (512 x 16) and timings (64 x 33)
// sit in synchronous memories with registered reads; their contents are
// undefined until written, and no clearing pass runs after reset.
module waypoint_trajectory_interpolator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,      // joints_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,        // point_index, joint_index, position, move_ticks,
                                        // dwell_ticks, interp_mode, point_count, zero pad
    input  logic [2:0]  s_tuser,        // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,        // out_joint, command_position, current_point, zero pad
    output logic        m_tlast         // last
);
    import wtraj_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_TIM  = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIVS = 6'b001000,
        S_DIVW = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    // Unpack the input word
    logic [PT_W-1:0]   in_pi;
    logic [JT_W-1:0]   in_ji;
    logic [POS_W-1:0]  in_pos;
    logic [TICK_W-1:0] in_mv, in_dw;
    logic              in_md;
    logic [6:0]        in_pc;
    func_t             in_func;
    logic              s_acc;

    assign in_pi   = s_tdata[5:0];
    assign in_ji   = s_tdata[8:6];
    assign in_pos  = s_tdata[24:9];
    assign in_mv   = s_tdata[40:25];
    assign in_dw   = s_tdata[56:41];
    assign in_md   = s_tdata[57];
    assign in_pc   = s_tdata[64:58];
    assign in_func = func_t'(s_tuser);

    state_t             state_reg, state_next;
    logic [3:0]         jiu_reg;
    logic [JT_W:0]      n_joints;
    logic [POS_W-1:0]   latched_reg [MAX_JOINTS];
    logic [PT_W:0]      tp_reg, tp_next;
    logic [PT_W:0]      rl_reg, rl_next;
    logic [EL_W-1:0]    el_reg, el_next;
    logic               run_reg, run_next;
    phase_t             ph_reg, ph_next;
    logic [JT_W-1:0]    j_reg, j_next;

    logic [POS_W-1:0]   pos_mem [MAX_POINTS*MAX_JOINTS];
    timing_t            tim_mem [MAX_POINTS];
    timing_t            tim_q;
    logic [POS_W-1:0]   end_q, prev_q;

    logic [POS_W-1:0]   start_reg;
    logic               neg_reg;
    logic [PROD_W-1:0]  mag_reg;
    logic [POS_W-1:0]   cmd_reg, cmd_next;
    logic               mv_reg;
    logic               lst_reg;

    div_req_t           dreq;
    logic               ddone;
    logic [PROD_W-1:0]  dquo;

    logic [TICK_W-1:0]  m_eff;
    logic               lin_act;
    logic [TICK_W:0]    limit;
    logic signed [POS_W:0]  diff;
    logic signed [PROD_W+1:0] prod;
    logic signed [POS_W+1:0]  qs;
    logic [POS_W+1:0]   sum;
    logic [POS_W-1:0]   start_sel;
    logic               last_j;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // Clamp joints_in_use to 1..MAX_JOINTS
    always_comb begin
        if (jiu_reg == 4'd0)
            n_joints = (JT_W+1)'(1);
        else if (jiu_reg > 4'(MAX_JOINTS))
            n_joints = (JT_W+1)'(MAX_JOINTS);
        else
            n_joints = jiu_reg[JT_W:0];
    end

    assign m_eff   = (tim_q.move != '0) ? tim_q.move : TICK_W'(1);
    assign lin_act = tim_q.mode && (el_reg < {{(EL_W-TICK_W){1'b0}}, m_eff});
    assign limit   = (tim_q.mode ? {1'b0, m_eff} : {1'b0, tim_q.move}) + {1'b0, tim_q.dwell};
    assign last_j  = ({1'b0, j_reg} == n_joints - 1'b1);
    assign start_sel = (tp_reg == '0) ? latched_reg[j_reg] : prev_q;
    assign diff    = $signed({end_q[POS_W-1], end_q}) - $signed({start_sel[POS_W-1], start_sel});
    assign prod    = diff * $signed({2'b00, el_reg[TICK_W-1:0]});

    // Signed quotient added to the start position
    assign qs  = neg_reg ? -$signed({2'b00, dquo[POS_W-1:0]}) : $signed({2'b00, dquo[POS_W-1:0]});
    assign sum = {{2{start_reg[POS_W-1]}}, start_reg} + qs;

    assign dreq.start    = (state_reg == S_DIVS);
    assign dreq.dividend = mag_reg;
    assign dreq.divisor  = m_eff;

    wtraj_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (dreq),
        .done     (ddone),
        .quotient (dquo)
    );

    // Sequencer and run state
    always_comb begin
        state_next = state_reg;
        tp_next    = tp_reg;
        rl_next    = rl_reg;
        el_next    = el_reg;
        run_next   = run_reg;
        ph_next    = ph_reg;
        j_next     = j_reg;
        cmd_next   = cmd_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    priority case (in_func)
                        FN_START: begin
                            rl_next  = (in_pc > 7'(MAX_POINTS)) ? (PT_W+1)'(MAX_POINTS)
                                                                : in_pc[PT_W:0];
                            tp_next  = '0;
                            el_next  = '0;
                            run_next = (in_pc != '0);
                            ph_next  = PH_WAIT;
                        end
                        FN_SAMPLE: begin
                            if (ph_reg == PH_WAIT && {1'b0, in_ji} < n_joints &&
                                {1'b0, in_ji} == n_joints - 1'b1)
                                ph_next = PH_DONE;
                        end
                        FN_STOP: run_next = 1'b0;
                        FN_TICK: begin
                            if (run_reg) begin
                                if (el_reg != {EL_W{1'b1}})
                                    el_next = el_reg + 1'b1;
                                if (ph_reg == PH_DONE && tp_reg < rl_reg) begin
                                    j_next     = '0;
                                    state_next = S_TIM;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_TIM: state_next = S_MUL;
            S_MUL: begin
                if (lin_act) begin
                    state_next = S_DIVS;
                end else begin
                    cmd_next   = end_q;
                    state_next = S_OUT;
                end
            end
            S_DIVS: state_next = S_DIVW;
            S_DIVW: begin
                if (ddone) begin
                    cmd_next   = sum[POS_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    if (last_j) begin
                        state_next = S_IDLE;
                        if ({{(EL_W-TICK_W-1){1'b0}}, limit} < el_reg) begin
                            tp_next = tp_reg + 1'b1;
                            el_next = '0;
                            if (tp_reg + 1'b1 >= rl_reg)
                                run_next = 1'b0;
                        end
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_TIM;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            jiu_reg   <= 4'd8;
            tp_reg    <= '0;
            rl_reg    <= '0;
            el_reg    <= '0;
            run_reg   <= 1'b0;
            ph_reg    <= PH_IDLE;
            j_reg     <= '0;
            for (int i = 0; i < MAX_JOINTS; i++)
                latched_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            tp_reg    <= tp_next;
            rl_reg    <= rl_next;
            el_reg    <= el_next;
            run_reg   <= run_next;
            ph_reg    <= ph_next;
            j_reg     <= j_next;
            if (cfg_we)
                jiu_reg <= cfg_wdata;
            // Latch a start sample while waiting
            if (s_acc && in_func == FN_SAMPLE && ph_reg == PH_WAIT &&
                {1'b0, in_ji} < n_joints)
                latched_reg[in_ji] <= in_pos;
        end
        cmd_reg <= cmd_next;
    end

    // Waypoint memories: write on input words, read for the tick walk
    always_ff @(posedge aclk) begin
        if (s_acc && in_func == FN_WR_POS)
            pos_mem[{in_pi, in_ji}] <= in_pos;
        if (s_acc && in_func == FN_WR_TIM)
            tim_mem[in_pi] <= '{move: in_mv, dwell: in_dw, mode: in_md};
        if (s_acc && in_func == FN_TICK)
            tim_q <= tim_mem[tp_reg[PT_W-1:0]];
        if (state_reg == S_TIM) begin
            end_q  <= pos_mem[{tp_reg[PT_W-1:0], j_reg}];
            prev_q <= pos_mem[{tp_reg[PT_W-1:0] - 1'b1, j_reg}];
        end
    end

    // Register operands for the divide
    always_ff @(posedge aclk) begin
        if (state_reg == S_MUL) begin
            start_reg <= start_sel;
            neg_reg   <= prod[PROD_W+1];
            mag_reg   <= prod[PROD_W+1] ? PROD_W'(-prod) : prod[PROD_W-1:0];
        end
    end

    // Output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else begin
            mv_reg <= (state_next == S_OUT);
        end
        lst_reg <= last_j;
    end

    assign m_tvalid = mv_reg && (state_reg == S_OUT);
    assign m_tlast  = lst_reg;
    assign m_tdata  = {7'd0, tp_reg[PT_W-1:0], cmd_reg, j_reg};

endmodule

/* rtl/core/wtraj_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wtraj_pkg for widths and the request struct.
module wtraj_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  wtraj_pkg::div_req_t       req,
    output logic                      done,
    output logic [wtraj_pkg::PROD_W-1:0] quotient
);
    import wtraj_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [TICK_W:0]     rem_reg, rem_next;
    logic [PROD_W-1:0]   sh_reg, sh_next;
    logic [TICK_W-1:0]   dsr_reg, dsr_next;
    logic [TICK_W:0]     rem_sh;

    // Shift in one dividend bit, subtract when it fits
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dsr_next  = dsr_reg;
        rem_sh    = {rem_reg[TICK_W-1:0], sh_reg[PROD_W-1]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            sh_next   = req.dividend;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dsr_reg}) begin
                rem_next = rem_sh - {1'b0, dsr_reg};
                sh_next  = {sh_reg[PROD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                sh_next  = {sh_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(PROD_W-1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

/* rtl/core/wtraj_checker.sv */
// Port-level checks for the waypoint trajectory interpolator core.
// Depends on nothing but the top level's ports; bound to the top level below.
module wtraj_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    // Hold a stalled output word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // Take no input word while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // Reset clears the output
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // Joints run in order within a tick: the word after a non-final word is not joint zero
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid || m_tdata[2:0] != 3'd0)
        else $error("joint order broken within a tick");

endmodule

bind waypoint_trajectory_interpolator_core wtraj_checker u_wtraj_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
